>>> rtl/core/qvr_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and latencies for the quaternion vector rotate pipeline.
package qvr_pkg;

    localparam int unsigned DATA_W   = 32;
    // squared norm is at most 2^64
    localparam int unsigned NORM_W   = 65;
    // rotation matrix coefficients scaled by the norm, signed
    localparam int unsigned COEF_W   = 66;
    // numerator: three coefficient times component products
    localparam int unsigned NUM_W    = 100;
    // quotient bits produced by the divider
    localparam int unsigned QUO_W    = 32;
    // partial remainder width
    localparam int unsigned REM_W    = 66;
    localparam int unsigned N_COEF   = 9;

    localparam int unsigned PROD_LAT = 6;
    localparam int unsigned DIV_LAT  = QUO_W + 4;

    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic signed [DATA_W-1:0] q_x;
        logic signed [DATA_W-1:0] q_y;
        logic signed [DATA_W-1:0] q_z;
        logic signed [DATA_W-1:0] q_w;
        logic signed [DATA_W-1:0] v_x;
        logic signed [DATA_W-1:0] v_y;
        logic signed [DATA_W-1:0] v_z;
        logic signed [DATA_W-1:0] v_w;
    } t_qvr_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] r_x;
        logic signed [DATA_W-1:0] r_y;
        logic signed [DATA_W-1:0] r_z;
        logic signed [DATA_W-1:0] r_w;
        logic                     zero_norm;
    } t_qvr_out;

endpackage

>>> rtl/core/quaternion_vector_rotate.sv
`timescale 1ns / 1ps
// Pipeline from accepted input word to output word: 6 product stages, 36 divider stages
// and one output register; the restoring divider with its 32 iteration stages sets the depth.
// Throughput: one word per cycle; the whole pipeline holds while the output word is stalled.
// Reset clears only the stage valid bits; data registers are not reset.
module quaternion_vector_rotate (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  qvr_pkg::t_qvr_in  i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output qvr_pkg::t_qvr_out o_data
);

    localparam int unsigned SIDE_LAT = qvr_pkg::PROD_LAT + qvr_pkg::DIV_LAT;
    localparam int unsigned TOT_LAT  = SIDE_LAT + 1;

    logic                                  w_en;
    logic [TOT_LAT-1:0]                    r_vld;
    logic signed [qvr_pkg::DATA_W-1:0]     r_vw   [0:SIDE_LAT-1];
    logic                                  r_zero [0:qvr_pkg::DIV_LAT-1];
    qvr_pkg::t_qvr_out                     r_out;
    qvr_pkg::t_qvr_out                     n_out;

    logic [qvr_pkg::NORM_W-1:0]            w_norm;
    logic signed [qvr_pkg::NUM_W-1:0]      w_num_x, w_num_y, w_num_z;
    logic signed [qvr_pkg::DATA_W-1:0]     w_res_x, w_res_y, w_res_z;

    // pipeline advances unless the output word is held
    assign w_en    = !(r_vld[TOT_LAT-1] && i_stall);
    assign o_stall = !w_en;

    qvr_prod u_prod (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_data  (i_data),
        .o_norm  (w_norm),
        .o_num_x (w_num_x),
        .o_num_y (w_num_y),
        .o_num_z (w_num_z)
    );

    qvr_div u_div_x (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (w_num_x),
        .i_norm (w_norm),
        .o_res  (w_res_x)
    );

    qvr_div u_div_y (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (w_num_y),
        .i_norm (w_norm),
        .o_res  (w_res_y)
    );

    qvr_div u_div_z (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (w_num_z),
        .i_norm (w_norm),
        .o_res  (w_res_z)
    );

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[TOT_LAT-2:0], i_valid};
        end
    end

    // side channel: v_w and the zero norm flag
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_vw[0]   <= i_data.v_w;
            for (int k = 1; k < SIDE_LAT; k++) begin
                r_vw[k] <= r_vw[k-1];
            end
            r_zero[0] <= (w_norm == '0);
            for (int k = 1; k < qvr_pkg::DIV_LAT; k++) begin
                r_zero[k] <= r_zero[k-1];
            end
            r_out <= n_out;
        end
    end

    // output word assembly; a zero norm forces a zero vector
    always_comb begin
        n_out.zero_norm = r_zero[qvr_pkg::DIV_LAT-1];
        n_out.r_w       = r_vw[SIDE_LAT-1];
        if (r_zero[qvr_pkg::DIV_LAT-1]) begin
            n_out.r_x = '0;
            n_out.r_y = '0;
            n_out.r_z = '0;
        end else begin
            n_out.r_x = w_res_x;
            n_out.r_y = w_res_y;
            n_out.r_z = w_res_z;
        end
    end

    assign o_valid = r_vld[TOT_LAT-1];
    assign o_data  = r_out;

    // a stall is only raised by a held output word
    a_stall_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("stall raised without an output word");

    // a held pipeline keeps every valid bit
    a_hold_valids: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("valid bits moved during a stall");

    // zero norm words carry a zero vector
    a_zero_norm_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.zero_norm) |->
            (o_data.r_x == '0 && o_data.r_y == '0 && o_data.r_z == '0))
        else $error("zero norm word with nonzero vector");

endmodule

>>> rtl/core/qvr_prod.sv
`timescale 1ns / 1ps
// Product front end: squared norm and the three exact rotation numerators.
module qvr_prod (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  qvr_pkg::t_qvr_in                       i_data,
    output logic [qvr_pkg::NORM_W-1:0]             o_norm,
    output logic signed [qvr_pkg::NUM_W-1:0]       o_num_x,
    output logic signed [qvr_pkg::NUM_W-1:0]       o_num_y,
    output logic signed [qvr_pkg::NUM_W-1:0]       o_num_z
);

    localparam int unsigned PW = 2 * qvr_pkg::DATA_W;
    localparam int unsigned HW = qvr_pkg::COEF_W - qvr_pkg::DATA_W;

    // vector component that multiplies each coefficient (x:0, y:1, z:2)
    localparam logic [1:0] VSEL [0:qvr_pkg::N_COEF-1] = '{
        2'd0, 2'd1, 2'd2,
        2'd1, 2'd0, 2'd2,
        2'd2, 2'd0, 2'd1
    };

    function automatic logic signed [qvr_pkg::COEF_W-1:0] ext(input logic signed [PW-1:0] p);
        return {{(qvr_pkg::COEF_W-PW){p[PW-1]}}, p};
    endfunction

    // stage 1: input word
    qvr_pkg::t_qvr_in r1_q;

    // stage 2: pairwise products
    logic signed [PW-1:0] r2_xx, r2_yy, r2_zz, r2_ww;
    logic signed [PW-1:0] r2_xy, r2_xz, r2_yz, r2_wx, r2_wy, r2_wz;
    logic signed [qvr_pkg::DATA_W-1:0] r2_v [0:2];

    // stage 3: norm and coefficients
    logic [qvr_pkg::NORM_W-1:0]          r3_norm;
    logic signed [qvr_pkg::COEF_W-1:0]   r3_c [0:qvr_pkg::N_COEF-1];
    logic signed [qvr_pkg::DATA_W-1:0]   r3_v [0:2];

    // stage 4: split products
    logic [qvr_pkg::NORM_W-1:0]             r4_norm;
    logic signed [qvr_pkg::DATA_W+qvr_pkg::DATA_W:0] r4_pl [0:qvr_pkg::N_COEF-1];
    logic signed [qvr_pkg::DATA_W+HW-1:0]   r4_ph [0:qvr_pkg::N_COEF-1];

    // stage 5: full products
    logic [qvr_pkg::NORM_W-1:0]          r5_norm;
    logic signed [qvr_pkg::NUM_W-1:0]    r5_p [0:qvr_pkg::N_COEF-1];

    // stage 6: numerators
    logic [qvr_pkg::NORM_W-1:0]          r6_norm;
    logic signed [qvr_pkg::NUM_W-1:0]    r6_num_x, r6_num_y, r6_num_z;

    logic [qvr_pkg::NORM_W-1:0]          n_norm;
    logic signed [qvr_pkg::COEF_W-1:0]   n_c [0:qvr_pkg::N_COEF-1];

    // coefficient forming
    always_comb begin
        n_norm = {1'b0, r2_xx} + {1'b0, r2_yy} + {1'b0, r2_zz} + {1'b0, r2_ww};
        n_c[0] = ext(r2_ww) + ext(r2_xx) - ext(r2_yy) - ext(r2_zz);
        n_c[1] = (ext(r2_xy) - ext(r2_wz)) <<< 1;
        n_c[2] = (ext(r2_xz) + ext(r2_wy)) <<< 1;
        n_c[3] = ext(r2_ww) - ext(r2_xx) + ext(r2_yy) - ext(r2_zz);
        n_c[4] = (ext(r2_xy) + ext(r2_wz)) <<< 1;
        n_c[5] = (ext(r2_yz) - ext(r2_wx)) <<< 1;
        n_c[6] = ext(r2_ww) - ext(r2_xx) - ext(r2_yy) + ext(r2_zz);
        n_c[7] = (ext(r2_xz) - ext(r2_wy)) <<< 1;
        n_c[8] = (ext(r2_yz) + ext(r2_wx)) <<< 1;
    end

    // pipeline registers, all held while stalled
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_q <= i_data;

            r2_xx <= r1_q.q_x * r1_q.q_x;
            r2_yy <= r1_q.q_y * r1_q.q_y;
            r2_zz <= r1_q.q_z * r1_q.q_z;
            r2_ww <= r1_q.q_w * r1_q.q_w;
            r2_xy <= r1_q.q_x * r1_q.q_y;
            r2_xz <= r1_q.q_x * r1_q.q_z;
            r2_yz <= r1_q.q_y * r1_q.q_z;
            r2_wx <= r1_q.q_w * r1_q.q_x;
            r2_wy <= r1_q.q_w * r1_q.q_y;
            r2_wz <= r1_q.q_w * r1_q.q_z;
            r2_v[0] <= r1_q.v_x;
            r2_v[1] <= r1_q.v_y;
            r2_v[2] <= r1_q.v_z;

            r3_norm <= n_norm;
            for (int k = 0; k < qvr_pkg::N_COEF; k++) begin
                r3_c[k] <= n_c[k];
            end
            for (int j = 0; j < 3; j++) begin
                r3_v[j] <= r2_v[j];
            end

            // coefficient split into signed high and unsigned low halves
            r4_norm <= r3_norm;
            for (int k = 0; k < qvr_pkg::N_COEF; k++) begin
                r4_pl[k] <= r3_v[VSEL[k]] * $signed({1'b0, r3_c[k][qvr_pkg::DATA_W-1:0]});
                r4_ph[k] <= r3_v[VSEL[k]] *
                            $signed(r3_c[k][qvr_pkg::COEF_W-1:qvr_pkg::DATA_W]);
            end

            r5_norm <= r4_norm;
            for (int k = 0; k < qvr_pkg::N_COEF; k++) begin
                r5_p[k] <= (qvr_pkg::NUM_W'(r4_ph[k]) <<< qvr_pkg::DATA_W) +
                           qvr_pkg::NUM_W'(r4_pl[k]);
            end

            r6_norm  <= r5_norm;
            r6_num_x <= r5_p[0] + r5_p[1] + r5_p[2];
            r6_num_y <= r5_p[3] + r5_p[4] + r5_p[5];
            r6_num_z <= r5_p[6] + r5_p[7] + r5_p[8];
        end
    end

    assign o_norm  = r6_norm;
    assign o_num_x = r6_num_x;
    assign o_num_y = r6_num_y;
    assign o_num_z = r6_num_z;

endmodule

>>> rtl/core/qvr_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: numerator over norm, rounded and saturated to 32 bits.
module qvr_div (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [qvr_pkg::NUM_W-1:0]   i_num,
    input  logic [qvr_pkg::NORM_W-1:0]         i_norm,
    output logic signed [qvr_pkg::DATA_W-1:0]  o_res
);

    localparam int unsigned QW = qvr_pkg::QUO_W;
    localparam int unsigned RW = qvr_pkg::REM_W;

    // stage 1: sign and magnitude
    logic                          r_neg1;
    logic [qvr_pkg::NUM_W-1:0]     r_mag;
    logic [qvr_pkg::NORM_W-1:0]    r_norm1;

    // iteration stages, index 0 is the setup stage
    logic [RW-1:0]                 r_rem  [0:QW];
    logic [QW-1:0]                 r_low  [0:QW];
    logic [QW-1:0]                 r_q    [0:QW];
    logic [qvr_pkg::NORM_W-1:0]    r_norm [0:QW];
    logic                          r_neg  [0:QW];
    logic                          r_sat  [0:QW];

    // rounding stage
    logic [QW:0]                   r_qr;
    logic                          r_neg_r, r_sat_r;
    logic signed [qvr_pkg::DATA_W-1:0] r_res;

    logic [RW-1:0]                 n_t    [1:QW];
    logic                          n_ge   [1:QW];
    logic                          n_up;

    // one quotient bit per stage
    always_comb begin
        for (int k = 1; k <= QW; k++) begin
            n_t[k]  = {r_rem[k-1][RW-2:0], r_low[k-1][QW-1]};
            n_ge[k] = n_t[k] >= RW'(r_norm[k-1]);
        end
        n_up = {r_rem[QW], 1'b0} >= (RW + 1)'(r_norm[QW]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg1  <= i_num[qvr_pkg::NUM_W-1];
            r_mag   <= i_num[qvr_pkg::NUM_W-1] ? qvr_pkg::NUM_W'(-i_num)
                                               : qvr_pkg::NUM_W'(i_num);
            r_norm1 <= i_norm;

            // quotient of 2^32 or more always saturates
            r_sat[0]  <= r_mag >= qvr_pkg::NUM_W'({r_norm1, {QW{1'b0}}});
            r_rem[0]  <= r_mag[QW +: RW];
            r_low[0]  <= r_mag[QW-1:0];
            r_q[0]    <= '0;
            r_norm[0] <= r_norm1;
            r_neg[0]  <= r_neg1;

            for (int k = 1; k <= QW; k++) begin
                r_rem[k]  <= n_ge[k] ? n_t[k] - RW'(r_norm[k-1]) : n_t[k];
                r_low[k]  <= {r_low[k-1][QW-2:0], 1'b0};
                r_q[k]    <= {r_q[k-1][QW-2:0], n_ge[k]};
                r_norm[k] <= r_norm[k-1];
                r_neg[k]  <= r_neg[k-1];
                r_sat[k]  <= r_sat[k-1];
            end

            // round half away from zero on the magnitude
            r_qr    <= {1'b0, r_q[QW]} + (QW + 1)'(n_up);
            r_neg_r <= r_neg[QW];
            r_sat_r <= r_sat[QW];

            // a magnitude of 2^31 or more clamps; the negative limit is exact
            if (r_sat_r || r_qr[QW] || r_qr[QW-1]) begin
                r_res <= r_neg_r ? qvr_pkg::SAT_MIN : qvr_pkg::SAT_MAX;
            end else if (r_neg_r) begin
                r_res <= -$signed(r_qr[QW-1:0]);
            end else begin
                r_res <= $signed(r_qr[QW-1:0]);
            end
        end
    end

    assign o_res = r_res;

endmodule

>>> verif/quaternion_vector_rotate_tb.sv
`timescale 1ns / 1ps
// Testbench for quaternion_vector_rotate: exact predictor, scoreboard, directed and random traffic.

// Scoreboard: predicts each rotated word exactly and checks outputs in order
class qvr_scoreboard;
    qvr_pkg::t_qvr_out rot_q[$];
    int unsigned       n_err;

    function new();
        n_err = 0;
    endfunction

    // round(num / den), ties away from zero, saturated to 32 bits
    function logic signed [31:0] div_round_sat(logic signed [127:0] num,
                                               logic [127:0] den);
        logic [127:0] mag;
        logic [127:0] quo;
        logic [127:0] rem;
        logic         neg;
        neg = num < 0;
        mag = neg ? -num : num;
        quo = mag / den;
        rem = mag % den;
        if ((rem << 1) >= den)
            quo = quo + 1;
        if (neg) begin
            if (quo >= 128'h8000_0000)
                return qvr_pkg::SAT_MIN;
            return -quo[31:0];
        end
        if (quo > 128'h7FFF_FFFF)
            return qvr_pkg::SAT_MAX;
        return quo[31:0];
    endfunction

    // note an accepted input word and queue its expected rotation
    function void note_input(qvr_pkg::t_qvr_in d);
        logic signed [127:0] x, y, z, w, vx, vy, vz;
        logic signed [127:0] nrm, sgn, num_x, num_y, num_z;
        qvr_pkg::t_qvr_out   r;
        x  = d.q_x;  y  = d.q_y;  z  = d.q_z;  w = d.q_w;
        vx = d.v_x;  vy = d.v_y;  vz = d.v_z;
        nrm = x*x + y*y + z*z + w*w;
        r.r_w = d.v_w;
        if (nrm == 0) begin
            r.r_x = '0; r.r_y = '0; r.r_z = '0;
            r.zero_norm = 1'b1;
        end else begin
            sgn   = w*w - x*x - y*y - z*z;
            num_x = vx*(sgn + 2*x*x) + 2*x*(y*vy + z*vz) + 2*w*(y*vz - z*vy);
            num_y = vy*(sgn + 2*y*y) + 2*y*(x*vx + z*vz) + 2*w*(z*vx - x*vz);
            num_z = vz*(sgn + 2*z*z) + 2*z*(x*vx + y*vy) + 2*w*(x*vy - y*vx);
            r.r_x = div_round_sat(num_x, nrm);
            r.r_y = div_round_sat(num_y, nrm);
            r.r_z = div_round_sat(num_z, nrm);
            r.zero_norm = 1'b0;
        end
        rot_q.push_back(r);
    endfunction

    // compare an accepted output word with the oldest expectation
    function void check(qvr_pkg::t_qvr_out got);
        qvr_pkg::t_qvr_out exp_w;
        if (rot_q.size() == 0) begin
            $error("unexpected output word %h", got);
            n_err++;
            return;
        end
        exp_w = rot_q.pop_front();
        if (got.r_x !== exp_w.r_x) begin
            $error("r_x expected %0d got %0d", exp_w.r_x, got.r_x); n_err++;
        end
        if (got.r_y !== exp_w.r_y) begin
            $error("r_y expected %0d got %0d", exp_w.r_y, got.r_y); n_err++;
        end
        if (got.r_z !== exp_w.r_z) begin
            $error("r_z expected %0d got %0d", exp_w.r_z, got.r_z); n_err++;
        end
        if (got.r_w !== exp_w.r_w) begin
            $error("r_w expected %0d got %0d", exp_w.r_w, got.r_w); n_err++;
        end
        if (got.zero_norm !== exp_w.zero_norm) begin
            $error("zero_norm expected %0b got %0b", exp_w.zero_norm, got.zero_norm);
            n_err++;
        end
    endfunction

    function int unsigned pending();
        return rot_q.size();
    endfunction
endclass

module quaternion_vector_rotate_tb;

    localparam logic signed [31:0] ONE  = 32'sh0001_0000;
    localparam logic signed [31:0] HALF = 32'sh0000_8000;
    // sin(45 deg) in Q16.16
    localparam logic signed [31:0] S45  = 32'sh0000_B505;
    localparam logic signed [31:0] SMAX = qvr_pkg::SAT_MAX;
    localparam logic signed [31:0] SMIN = qvr_pkg::SAT_MIN;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    qvr_pkg::t_qvr_in   i_data = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    qvr_pkg::t_qvr_out  o_data;

    bit        hold_req = 1'b0;
    bit        hold_done = 1'b0;

    qvr_scoreboard sb = new();

    quaternion_vector_rotate DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always #5 i_clk = ~i_clk;

    // output checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check(o_data);
    end

    // receiver stall pattern, with one long hold-off on request
    always @(posedge i_clk) begin
        int unsigned mode;
        int unsigned cnt;
        if (hold_req && !hold_done) begin
            if (cnt < 300) begin
                i_stall <= 1'b1;
                cnt++;
            end else begin
                hold_done = 1'b1;
                i_stall <= 1'b0;
                cnt = 0;
            end
        end else begin
            if (cnt == 0) begin
                mode = $urandom_range(0, 3);
                cnt  = $urandom_range(20, 200);
            end else begin
                cnt--;
            end
            case (mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 9) < 3);
                2: i_stall <= ($urandom_range(0, 9) < 7);
                default: i_stall <= cnt[0];
            endcase
        end
    end

    // offer one word and wait until it is taken
    task automatic push_word(input qvr_pkg::t_qvr_in d);
        i_valid <= 1'b1;
        i_data  <= d;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(d);
    endtask

    task automatic idle_gap(input int unsigned cycles);
        if (cycles > 0) begin
            i_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // wait on clock edges until every expected word has come out
    task automatic drain();
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_comp(input int unsigned kind);
        case (kind)
            0: return $urandom();
            1: return $signed($urandom_range(0, 2 * ONE)) - ONE;
            2: return $signed($urandom_range(0, 511)) - 256;
            default: return $urandom_range(0, 1) ? SMAX : SMIN;
        endcase
    endfunction

    function automatic qvr_pkg::t_qvr_in make_word(
            input logic signed [31:0] qx, qy, qz, qw,
            input logic signed [31:0] vx, vy, vz, vw);
        qvr_pkg::t_qvr_in d;
        d.q_x = qx; d.q_y = qy; d.q_z = qz; d.q_w = qw;
        d.v_x = vx; d.v_y = vy; d.v_z = vz; d.v_w = vw;
        return d;
    endfunction

    function automatic qvr_pkg::t_qvr_in rand_word();
        qvr_pkg::t_qvr_in d;
        int unsigned      sel;
        int unsigned      qk;
        int unsigned      vk;
        sel = $urandom_range(0, 99);
        qk  = sel < 30 ? 0 : sel < 80 ? 1 : sel < 93 ? 2 : 3;
        vk  = $urandom_range(0, 3);
        d.q_x = rand_comp(qk); d.q_y = rand_comp(qk);
        d.q_z = rand_comp(qk); d.q_w = rand_comp(qk);
        // occasional zero quaternion or single-axis quaternion
        if ($urandom_range(0, 19) == 0) begin
            d.q_x = '0; d.q_y = '0; d.q_z = '0; d.q_w = '0;
        end else if ($urandom_range(0, 9) == 0) begin
            d.q_y = '0; d.q_z = '0;
        end
        d.v_x = rand_comp(vk > 2 ? 0 : vk); d.v_y = rand_comp(vk);
        d.v_z = rand_comp(vk == 3 ? 0 : vk); d.v_w = $urandom();
        return d;
    endfunction

    // stimulus
    initial begin
        qvr_pkg::t_qvr_in d;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: identity, zero quaternion, axis rotations, tiny and huge norms
        push_word(make_word(0, 0, 0, ONE, ONE, 2*ONE, -3*ONE, 32'sh1234_5678));
        push_word(make_word(0, 0, 0, 0, ONE, ONE, ONE, SMIN));
        push_word(make_word(0, 0, 0, 0, SMAX, SMIN, 0, SMAX));
        push_word(make_word(S45, 0, 0, S45, 0, ONE, 0, 0));
        push_word(make_word(0, S45, 0, S45, 0, 0, ONE, -1));
        push_word(make_word(0, 0, S45, S45, ONE, 0, 0, 1));
        push_word(make_word(ONE, 0, 0, 0, ONE, ONE, ONE, 0));
        push_word(make_word(0, 0, 0, 1, SMAX, SMIN, SMAX, 0));
        push_word(make_word(1, 0, 0, 0, SMAX, SMAX, SMIN, 0));
        push_word(make_word(1, 1, 1, 1, SMAX, SMAX, SMAX, SMAX));
        push_word(make_word(SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN));
        push_word(make_word(SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX));
        push_word(make_word(SMAX, SMIN, SMAX, SMIN, ONE, -ONE, HALF, 0));
        push_word(make_word(HALF, HALF, HALF, HALF, SMAX, 0, SMIN, 32'shFFFF_FFFF));
        push_word(make_word(HALF, -HALF, HALF, -HALF, 3, -3, 1, 7));
        push_word(make_word(1, 2, 0, 0, 1, 0, 0, 0));
        push_word(make_word(0, 0, 3, 1, 0, 1, 0, 0));
        push_word(make_word(-ONE, 0, 0, 0, -1, -1, -1, 0));
        idle_gap(1);
        drain();

        // random traffic in bursts; long receiver hold-off while still offering
        for (int i = 0; i < 1100; i++) begin
            if (i == 300)
                hold_req = 1'b1;
            if (i == 700) begin
                idle_gap(1);
                drain();
            end
            d = rand_word();
            push_word(d);
            if ($urandom_range(0, 7) == 0)
                idle_gap($urandom_range(1, 12));
        end
        i_valid <= 1'b0;

        drain();
        repeat (60) @(posedge i_clk);
        if (sb.n_err == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // timeout
    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
